### rtl/temperature_scratchpad_checker_top_macros.svh
// ----------------------------------------------------------------------------
// Temperature scratchpad checker assertion macros
// Shared concurrent assertion forms for the checker RTL.
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_SCRATCHPAD_CHECKER_TOP_MACROS_SVH
`define TEMPERATURE_SCRATCHPAD_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsc assertion failed");

// Next-cycle implication, disabled during reset.
`define TSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsc assertion failed");

`endif

### rtl/tsc_pkg.sv
// ----------------------------------------------------------------------------
// Temperature scratchpad checker package
// Status codes, resolution codes, frame snapshot type and CRC-8 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package tsc_pkg;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_CRC_ERROR    = 3'd1,
      STATUS_BAD_RESERVED = 3'd2,
      STATUS_POWER_ON     = 3'd3,
      STATUS_OUT_OF_RANGE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      RES_9BIT  = 2'd0,
      RES_10BIT = 2'd1,
      RES_11BIT = 2'd2,
      RES_12BIT = 2'd3
   } resolution_type;

   typedef struct packed {
      logic [7:0] crc;
      logic [7:0] low_byte;
      logic [7:0] high_byte;
      logic       reserved_good;
   } frame_type;

   localparam logic [7:0] CRC_POLY       = 8'h8C;
   localparam logic [7:0] RESERVED_VALUE = 8'h10;
   localparam logic [7:0] POR_LOW        = 8'h50;
   localparam logic [7:0] POR_HIGH       = 8'h05;
   localparam logic [3:0] FRAME_BYTES    = 4'd9;
   localparam logic [3:0] LAST_POS       = 4'd8;
   localparam logic [3:0] POS_TEMP_LOW   = 4'd0;
   localparam logic [3:0] POS_TEMP_HIGH  = 4'd1;
   localparam logic [3:0] POS_RESERVED   = 4'd7;

   localparam logic signed [15:0] RAW_LOW_LIMIT  = -16'sd880;
   localparam logic signed [15:0] RAW_HIGH_LIMIT = 16'sd2000;
   localparam logic signed [11:0] TEMP_LOW_LIMIT  = -12'sd880;
   localparam logic signed [11:0] TEMP_HIGH_LIMIT = 12'sd2000;

   // Reflected CRC-8, one byte per call.
   function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### rtl/tsc_req_if.sv
// ----------------------------------------------------------------------------
// Scratchpad byte channel
// Valid/ready channel carrying one scratchpad byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_req_if;
   logic       valid;
   logic       ready;
   logic       frame_start;
   logic [7:0] byte_value;

   modport source (output valid, output frame_start, output byte_value, input ready);
   modport sink   (input valid, input frame_start, input byte_value, output ready);
endinterface

`default_nettype wire

### rtl/tsc_rsp_if.sv
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel carrying one frame status and temperature per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsc_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         frame_status;
   logic signed [11:0] temperature_sixteenths;

   modport source (output valid, output frame_status, output temperature_sixteenths,
                   input ready);
   modport sink   (input valid, input frame_status, input temperature_sixteenths,
                   output ready);
endinterface

`default_nettype wire

### rtl/tsc_frame_accum.sv
// ----------------------------------------------------------------------------
// Scratchpad frame accumulator
// Runs the CRC over incoming bytes, keeps temperature and reserved-byte state,
// and registers a frame snapshot on the ninth byte.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_frame_accum (
   input  wire logic          clock,
   input  wire logic          reset,
   tsc_req_if.sink            req_chan,
   input  wire logic          snap_take,
   output logic               snap_valid,
   output tsc_pkg::frame_type snap
);

   logic [7:0]         crc_ff, crc_in;
   logic [3:0]         pos_ff, pos_in;
   logic [7:0]         low_ff, low_in;
   logic [7:0]         high_ff, high_in;
   logic               rsv_ff, rsv_in;
   logic               snap_valid_ff, snap_valid_in;
   tsc_pkg::frame_type snap_ff, snap_in;

   logic       accept;
   logic       last_byte;
   logic [3:0] pos_base;
   logic [7:0] crc_base;
   logic [7:0] crc_next;

   assign req_chan.ready = !snap_valid_ff || snap_take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      pos_base = pos_ff;
      crc_base = crc_ff;
      if (req_chan.frame_start || (pos_ff >= tsc_pkg::FRAME_BYTES)) begin
         pos_base = '0;
      end
      if (req_chan.frame_start) begin
         crc_base = '0;
      end
      crc_next  = tsc_pkg::crc_update(crc_base, req_chan.byte_value);
      last_byte = (pos_base == tsc_pkg::LAST_POS);
   end

   always_comb begin
      crc_in        = crc_ff;
      pos_in        = pos_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      rsv_in        = rsv_ff;
      snap_in       = snap_ff;
      snap_valid_in = snap_valid_ff && !snap_take;
      if (accept) begin
         if (pos_base == tsc_pkg::POS_TEMP_LOW) begin
            low_in = req_chan.byte_value;
         end
         if (pos_base == tsc_pkg::POS_TEMP_HIGH) begin
            high_in = req_chan.byte_value;
         end
         if (pos_base == tsc_pkg::POS_RESERVED) begin
            rsv_in = (req_chan.byte_value == tsc_pkg::RESERVED_VALUE);
         end
         if (last_byte) begin
            // frame complete: hand off snapshot, restart count and CRC
            crc_in                = '0;
            pos_in                = '0;
            snap_in.crc           = crc_next;
            snap_in.low_byte      = low_ff;
            snap_in.high_byte     = high_ff;
            snap_in.reserved_good = rsv_ff;
            snap_valid_in         = 1'b1;
         end else begin
            crc_in = crc_next;
            pos_in = pos_base + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff        <= '0;
         pos_ff        <= '0;
         low_ff        <= '0;
         high_ff       <= '0;
         rsv_ff        <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         crc_ff        <= crc_in;
         pos_ff        <= pos_in;
         low_ff        <= low_in;
         high_ff       <= high_in;
         rsv_ff        <= rsv_in;
         snap_valid_ff <= snap_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

`default_nettype wire

### rtl/tsc_frame_eval.sv
// ----------------------------------------------------------------------------
// Scratchpad frame evaluator
// Holds the resolution register, classifies a completed frame and drives the
// registered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module tsc_frame_eval (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wr_en,
   input  wire logic [1:0]         csr_wr_data,
   input  wire logic               snap_valid,
   input  wire tsc_pkg::frame_type snap,
   output logic                    snap_take,
   tsc_rsp_if.source               rsp_chan
);

   tsc_pkg::resolution_type mode_ff, mode_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   tsc_pkg::status_type     status_ff, status_in;
   logic signed [11:0]      temp_ff, temp_in;

   logic               load;
   logic [15:0]        raw;
   logic [15:0]        masked;
   logic signed [15:0] val;

   assign mode_in   = csr_wr_en ? tsc_pkg::resolution_type'(csr_wr_data) : mode_ff;
   assign load      = !rsp_valid_ff || rsp_chan.ready;
   assign snap_take = snap_valid && load;

   always_comb begin
      raw = {snap.high_byte, snap.low_byte};
      unique case (mode_ff)
         tsc_pkg::RES_9BIT:  masked = raw & ~16'd7;
         tsc_pkg::RES_10BIT: masked = raw & ~16'd3;
         tsc_pkg::RES_11BIT: masked = raw & ~16'd1;
         tsc_pkg::RES_12BIT: masked = raw;
         default:            masked = raw;
      endcase
      val = signed'(masked);

      priority if (snap.crc != 8'd0) begin
         status_in = tsc_pkg::STATUS_CRC_ERROR;
      end else if (!snap.reserved_good) begin
         status_in = tsc_pkg::STATUS_BAD_RESERVED;
      end else if ((snap.low_byte == tsc_pkg::POR_LOW) &&
                   (snap.high_byte == tsc_pkg::POR_HIGH)) begin
         status_in = tsc_pkg::STATUS_POWER_ON;
      end else if (!((val > tsc_pkg::RAW_LOW_LIMIT) && (val < tsc_pkg::RAW_HIGH_LIMIT))) begin
         status_in = tsc_pkg::STATUS_OUT_OF_RANGE;
      end else begin
         status_in = tsc_pkg::STATUS_OK;
      end

      temp_in = (status_in == tsc_pkg::STATUS_OK) ? val[11:0] : 12'sd0;
   end

   always_comb begin
      rsp_valid_in = load ? snap_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= tsc_pkg::RES_12BIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result payload while the sink stalls
   always_ff @(posedge clock) begin
      if (snap_take) begin
         status_ff <= status_in;
         temp_ff   <= temp_in;
      end
   end

   assign rsp_chan.valid                  = rsp_valid_ff;
   assign rsp_chan.frame_status           = status_ff;
   assign rsp_chan.temperature_sixteenths = temp_ff;

endmodule

`default_nettype wire

### rtl/temperature_scratchpad_checker_top.sv
// ----------------------------------------------------------------------------
// Temperature scratchpad checker
// Checks nine-byte sensor scratchpad frames and reports status and temperature.
// ----------------------------------------------------------------------------
// Accepts one scratchpad byte per cycle on req_chan while results drain, with no
// gap needed between frames. A byte-wide unrolled CRC-8 step per cycle sets that
// rate. The ninth byte of a frame yields one beat on rsp_chan via the snapshot
// and result registers; other bytes produce none. A frame_start byte restarts
// the count and drops any partial frame. Write csr_wr_data to set the resolution
// (0 = 9 bits through 3 = 12 bits, reset 12 bits) only while no frame is in flight.
`default_nettype none
`include "temperature_scratchpad_checker_top_macros.svh"

module temperature_scratchpad_checker_top (
   input  wire logic       clock,
   input  wire logic       reset,
   tsc_req_if.sink         req_chan,
   tsc_rsp_if.source       rsp_chan,
   input  wire logic       csr_wr_en,
   input  wire logic [1:0] csr_wr_data
);

   logic               snap_valid;
   logic               snap_take;
   tsc_pkg::frame_type snap;

   tsc_frame_accum u_accum (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .snap_take  (snap_take),
      .snap_valid (snap_valid),
      .snap       (snap)
   );

   tsc_frame_eval u_eval (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .snap_valid  (snap_valid),
      .snap        (snap),
      .snap_take   (snap_take),
      .rsp_chan    (rsp_chan)
   );

   `TSC_ASSERT_IMPL(a_ok_in_range, clock, reset, rsp_chan.valid && (rsp_chan.frame_status == tsc_pkg::STATUS_OK), (rsp_chan.temperature_sixteenths > tsc_pkg::TEMP_LOW_LIMIT) && (rsp_chan.temperature_sixteenths < tsc_pkg::TEMP_HIGH_LIMIT))
   `TSC_ASSERT_IMPL(a_fail_zero_temp, clock, reset, rsp_chan.valid && (rsp_chan.frame_status != tsc_pkg::STATUS_OK), rsp_chan.temperature_sixteenths == 12'sd0)
   `TSC_ASSERT_NEXT(a_snap_held, clock, reset, snap_valid && !snap_take, snap_valid && $stable(snap))

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Temperature scratchpad checker testbench
// Sends nine-byte scratchpad frames, partial frames and stray bytes in random
// bursts while the result side stalls on its own pattern. A local decoder
// tracks CRC, temperature and reserved byte per beat and queues the expected
// status and reading, which the monitor compares field by field.
// ----------------------------------------------------------------------------

module tb_top;
   import tsc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 6;

   typedef struct packed {
      logic       start;
      logic [7:0] data;
   } scratch_byte_t;

   typedef struct packed {
      status_type         status;
      logic signed [11:0] temp;
   } reading_t;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [1:0] csr_wr_data;

   tsc_req_if req_chan ();
   tsc_rsp_if rsp_chan ();

   temperature_scratchpad_checker_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   scratch_byte_t outgoing_bytes[$];
   reading_t      expected_readings[$];
   int            mismatches = 0;
   int            cycle_count = 0;

   // decoder state
   resolution_type active_resolution = RES_12BIT;
   logic [7:0]     frame_crc = '0;
   logic [3:0]     frame_pos = '0;
   logic [7:0]     temp_low = '0;
   logic [7:0]     temp_high = '0;
   logic           reserved_ok = 1'b0;

   // driver and receiver state
   scratch_byte_t next_byte;
   int            burst_left = 0;
   int            gap_left = 0;
   int            stall_pct = 0;
   int            stall_epoch = 0;
   reading_t      got;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [7:0] crc8_reflected_step(input logic [7:0] crc,
                                                      input logic [7:0] data);
      logic [7:0] acc;
      logic       fb;
      acc = crc;
      for (int i = 0; i < 8; i++) begin
         fb = acc[0] ^ data[i];
         acc = acc >> 1;
         if (fb) acc = acc ^ CRC_POLY;
      end
      return acc;
   endfunction

   // Advance the decoder by one accepted beat; queue a reading on the ninth.
   task automatic decode_scratchpad_byte(input logic start, input logic [7:0] data);
      logic [3:0]         pos;
      logic [15:0]        raw;
      logic signed [15:0] reading;
      reading_t           exp_rd;
      if (start) begin
         frame_crc = '0;
         frame_pos = '0;
      end
      pos = (frame_pos > LAST_POS) ? '0 : frame_pos;
      frame_crc = crc8_reflected_step(frame_crc, data);
      if (pos == POS_TEMP_LOW) temp_low = data;
      else if (pos == POS_TEMP_HIGH) temp_high = data;
      else if (pos == POS_RESERVED) reserved_ok = (data == RESERVED_VALUE);
      if (pos != LAST_POS) begin
         frame_pos = pos + 4'd1;
         return;
      end
      raw = {temp_high, temp_low};
      case (active_resolution)
         RES_9BIT:  raw[2:0] = '0;
         RES_10BIT: raw[1:0] = '0;
         RES_11BIT: raw[0] = 1'b0;
         default: ;
      endcase
      reading = $signed(raw);
      exp_rd.temp = '0;
      if (frame_crc != 8'd0) exp_rd.status = STATUS_CRC_ERROR;
      else if (!reserved_ok) exp_rd.status = STATUS_BAD_RESERVED;
      else if (temp_low == POR_LOW && temp_high == POR_HIGH) exp_rd.status = STATUS_POWER_ON;
      else if (!(reading > RAW_LOW_LIMIT && reading < RAW_HIGH_LIMIT))
         exp_rd.status = STATUS_OUT_OF_RANGE;
      else begin
         exp_rd.status = STATUS_OK;
         exp_rd.temp = reading[11:0];
      end
      expected_readings.push_back(exp_rd);
      frame_crc = '0;
      frame_pos = '0;
   endtask

   task automatic push_byte(input logic start, input logic [7:0] data);
      scratch_byte_t sb;
      sb.start = start;
      sb.data = data;
      outgoing_bytes.push_back(sb);
   endtask

   task automatic queue_frame(input logic start, input logic [15:0] raw,
                              input logic reserved_good, input logic crc_good);
      logic [7:0] body [9];
      logic [7:0] crc;
      logic [7:0] junk;
      body[0] = raw[7:0];
      body[1] = raw[15:8];
      for (int i = 2; i < 7; i++) body[i] = 8'($urandom);
      if (reserved_good) body[7] = RESERVED_VALUE;
      else begin
         do junk = 8'($urandom); while (junk == RESERVED_VALUE);
         body[7] = junk;
      end
      crc = '0;
      for (int i = 0; i < 8; i++) crc = crc8_reflected_step(crc, body[i]);
      body[8] = crc_good ? crc : crc ^ 8'($urandom_range(1, 255));
      for (int i = 0; i < 9; i++) push_byte((i == 0) ? start : 1'b0, body[i]);
   endtask

   function automatic logic [15:0] pick_raw();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: v = int'($urandom_range(0, 2880)) - 880;
         5: begin
            case ($urandom_range(0, 9))
               0: v = -880;
               1: v = -879;
               2: v = -878;
               3: v = -873;
               4: v = 1999;
               5: v = 1998;
               6: v = 2000;
               7: v = 2007;
               8: v = -1;
               default: v = 0;
            endcase
         end
         6, 7: v = int'($urandom_range(0, 65535));
         8: v = -int'($urandom_range(1, 16));
         default: v = 16'h0550;
      endcase
      return v[15:0];
   endfunction

   task automatic fill_random(input int n_items);
      int target;
      int len;
      target = outgoing_bytes.size() + n_items;
      while (outgoing_bytes.size() < target) begin
         case ($urandom_range(0, 19))
            0, 1: begin
               // truncated frame, cut off by a following frame_start or run on by bytes without one
               len = $urandom_range(1, 8);
               for (int i = 0; i < len; i++) push_byte(i == 0, 8'($urandom));
            end
            2, 3: begin
               len = $urandom_range(1, 5);
               for (int i = 0; i < len; i++) push_byte($urandom_range(0, 3) == 0, 8'($urandom));
            end
            4: queue_frame(1'b1, 16'h0550, 1'b1, $urandom_range(0, 7) != 0);
            default:
               queue_frame($urandom_range(0, 6) != 0, pick_raw(),
                           $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
         endcase
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (outgoing_bytes.size() != 0 || req_chan.valid || expected_readings.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input resolution_type res, input int n_items);
      wait_drained();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= res;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      active_resolution = res;
      fill_random(n_items);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (gap_left != 0) begin
            gap_left--;
            req_chan.valid <= 1'b0;
         end else if (outgoing_bytes.size() != 0) begin
            next_byte = outgoing_bytes.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.frame_start <= next_byte.start;
            req_chan.byte_value <= next_byte.data;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // monitor: predict from accepted bytes, check accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            decode_scratchpad_byte(req_chan.frame_start, req_chan.byte_value);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_readings.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result beat, actual status %0d temp %0d", $time,
                        rsp_chan.frame_status, rsp_chan.temperature_sixteenths);
            end else begin
               got = expected_readings.pop_front();
               if (rsp_chan.frame_status !== got.status) begin
                  mismatches++;
                  $display("%0t: frame_status expected %0d actual %0d", $time,
                           got.status, rsp_chan.frame_status);
               end
               if (rsp_chan.temperature_sixteenths !== got.temp) begin
                  mismatches++;
                  $display("%0t: temperature_sixteenths expected %0d actual %0d", $time,
                           got.temp, rsp_chan.temperature_sixteenths);
               end
            end
         end
      end
      // hold each stall level for a while, including stretches with no stall
      if (stall_epoch == 0) begin
         stall_epoch = $urandom_range(20, 80);
         case ($urandom_range(0, 4))
            0, 1: stall_pct = 0;
            2: stall_pct = 25;
            3: stall_pct = 60;
            default: stall_pct = 85;
         endcase
      end else begin
         stall_epoch--;
      end
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_chan.valid = 1'b0;
      req_chan.frame_start = 1'b0;
      req_chan.byte_value = '0;
      rsp_chan.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: top of range, bottom edge via wrap, dropped partial, power-on value
      queue_frame(1'b1, 16'h07CF, 1'b1, 1'b1);
      queue_frame(1'b0, 16'hFC90, 1'b1, 1'b1);
      push_byte(1'b1, 8'h12);
      push_byte(1'b0, 8'h34);
      push_byte(1'b0, 8'h56);
      queue_frame(1'b1, 16'h0550, 1'b1, 1'b1);

      run_phase(RES_9BIT, 118);
      run_phase(RES_11BIT, 118);
      run_phase(RES_12BIT, 118);
      run_phase(RES_10BIT, 118);
      run_phase(RES_9BIT, 118);
      run_phase(RES_12BIT, 118);
      wait_drained();

      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### temperature_scratchpad_checker_top.f
+incdir+rtl
rtl/tsc_pkg.sv
rtl/tsc_req_if.sv
rtl/tsc_rsp_if.sv
rtl/tsc_frame_accum.sv
rtl/tsc_frame_eval.sv
rtl/temperature_scratchpad_checker_top.sv
test/tb_top.sv
